// ----- rtl/etok_pkg.sv -----
// Shared types, token kinds, scanner mode codes and keyword table
// for the expression tokenizer. No dependencies.
package etok_pkg;

  localparam int TEXT_BYTES_DEF = 8;
  localparam int MAX_FRAC_DEF   = 9;
  localparam int KEYWORD_COUNT  = 12;
  localparam int QDEPTH         = 4;
  localparam int QAW            = 2;

  localparam logic [4:0] K_INT     = 5'd0;
  localparam logic [4:0] K_DEC     = 5'd1;
  localparam logic [4:0] K_PLUS    = 5'd2;
  localparam logic [4:0] K_MINUS   = 5'd3;
  localparam logic [4:0] K_STAR    = 5'd4;
  localparam logic [4:0] K_SLASH   = 5'd5;
  localparam logic [4:0] K_LPAR    = 5'd6;
  localparam logic [4:0] K_RPAR    = 5'd7;
  localparam logic [4:0] K_ASSIGN  = 5'd8;
  localparam logic [4:0] K_SEMI    = 5'd9;
  localparam logic [4:0] K_COMPARE = 5'd10;
  localparam logic [4:0] K_IDENT   = 5'd11;
  localparam logic [4:0] K_END     = 5'd22;
  localparam logic [4:0] K_ERROR   = 5'd23;

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_IDENT = 3'd1;
  localparam logic [2:0] M_INT   = 3'd2;
  localparam logic [2:0] M_DEC   = 3'd3;
  localparam logic [2:0] M_EQ    = 3'd4;
  localparam logic [2:0] M_BANG  = 3'd5;
  localparam logic [2:0] M_REL   = 3'd6;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [30:0] ival;
    logic [29:0] fval;
    logic [3:0]  fdig;
    logic [63:0] text;
    logic [4:0]  tlen;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic [63:0] word;
    logic [4:0]  len;
    logic [4:0]  kind;
  } kw_t;

  localparam kw_t KW_TABLE [KEYWORD_COUNT] = '{
    '{64'h0000_0000_6572_696C, 5'd4, 5'd12},  // lire
    '{64'h0000_6572_6972_6365, 5'd6, 5'd13},  // ecrire
    '{64'h0000_0000_0000_6973, 5'd2, 5'd14},  // si
    '{64'h0000_0073_726F_6C61, 5'd5, 5'd15},  // alors
    '{64'h0000_006E_6F6E_6973, 5'd5, 5'd16},  // sinon
    '{64'h0000_0000_0069_7366, 5'd3, 5'd17},  // fsi
    '{64'h0000_0000_0000_7465, 5'd2, 5'd18},  // et
    '{64'h0000_0000_0000_756F, 5'd2, 5'd18},  // ou
    '{64'h0000_0000_006E_6F6E, 5'd3, 5'd18},  // non
    '{64'h0065_7571_746E_6174, 5'd7, 5'd19},  // tantque
    '{64'h0000_0065_7269_6166, 5'd5, 5'd20},  // faire
    '{64'h0000_0000_7469_6166, 5'd4, 5'd21}   // fait
  };

endpackage

// ----- rtl/etok_front.sv -----
// Scanner front end: per-character state machine, emits up to two raw tokens.
// Depends on etok_pkg.
module etok_front #(
  parameter int TEXT_BYTES = etok_pkg::TEXT_BYTES_DEF,
  parameter int MAX_FRAC   = etok_pkg::MAX_FRAC_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc_en,
  input  logic [7:0]    char_code,
  input  logic          end_of_input,
  output logic [1:0]    push_cnt,
  output etok_pkg::tok_t tok0,
  output etok_pkg::tok_t tok1
);
  import etok_pkg::*;

  logic [2:0]  mode_r, mode_nxt;
  logic [4:0]  pk_r, pk_nxt;
  logic [63:0] text_r, text_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [30:0] iacc_r, iacc_nxt;
  logic [29:0] facc_r, facc_nxt;
  logic [3:0]  fcnt_r, fcnt_nxt;
  logic [15:0] line_r, line_nxt, col_r, col_nxt;
  logic [15:0] tline_r, tline_nxt, tcol_r, tcol_nxt;
  logic        err_r, err_nxt;

  function automatic logic [63:0] app_text(logic [63:0] t, logic [4:0] n, logic [7:0] c);
    app_text = t;
    if (n < 5'(TEXT_BYTES)) app_text = t | ({56'd0, c} << {n[2:0], 3'b000});
  endfunction

  function automatic logic [4:0] app_cnt(logic [4:0] n);
    app_cnt = (n < 5'd31) ? n + 5'd1 : n;
  endfunction

  function automatic tok_t mk(logic [4:0] k, logic [15:0] l, logic [15:0] cl,
                              logic [30:0] iv, logic [29:0] fv, logic [3:0] fd,
                              logic [63:0] tx, logic [4:0] tl);
    tok_t t;
    t.kind = k; t.line = l; t.col = cl; t.ival = iv; t.fval = fv; t.fdig = fd;
    t.text = tx; t.tlen = tl; t.last = 1'b0;
    mk = t;
  endfunction

  logic        is_dig, is_let, is_blank;
  logic [3:0]  dval;
  logic [34:0] iprod;
  logic [1:0]  n;
  logic        do_start, do_pend;
  logic [4:0]  pend_kind;
  logic [63:0] ptext;
  logic [4:0]  pcnt;
  tok_t        pend_tok, start_tok;
  logic        st_emit;
  logic [4:0]  single;

  assign is_dig   = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign is_let   = ((char_code >= 8'h61) && (char_code <= 8'h7A)) ||
                    ((char_code >= 8'h41) && (char_code <= 8'h5A));
  assign is_blank = (char_code == 8'h20) || (char_code == 8'h09) || (char_code == 8'h0A);
  assign dval     = 4'(char_code - 8'h30);
  assign iprod    = ({4'd0, iacc_r} << 3) + ({4'd0, iacc_r} << 1) + 35'(dval);

  always_comb begin
    mode_nxt = mode_r; pk_nxt = pk_r; text_nxt = text_r; cnt_nxt = cnt_r;
    iacc_nxt = iacc_r; facc_nxt = facc_r; fcnt_nxt = fcnt_r;
    line_nxt = line_r; col_nxt = col_r; tline_nxt = tline_r; tcol_nxt = tcol_r;
    err_nxt = err_r;
    tok0 = '0; tok1 = '0; n = 2'd0;
    do_start = 1'b0; do_pend = 1'b0; pend_kind = pk_r;
    ptext = text_r; pcnt = cnt_r;
    single = K_PLUS; st_emit = 1'b0;

    if (end_of_input) begin
      if (err_r || mode_r == M_EQ || mode_r == M_BANG || mode_r == M_REL) begin
        tok0 = mk(K_ERROR, line_r, col_r, '0, '0, '0, '0, '0);
        err_nxt = 1'b1;
        n = 2'd1;
      end else begin
        if (mode_r != M_IDLE) begin
          do_pend = 1'b1;
        end
      end
      mode_nxt = M_IDLE;
      line_nxt = 16'd1;
      col_nxt  = 16'd1;
    end else begin
      if (!err_r) begin
        unique case (mode_r)
          M_IDENT: begin
            if (is_let || is_dig) begin
              text_nxt = app_text(text_r, cnt_r, char_code); cnt_nxt = app_cnt(cnt_r);
            end else begin
              do_pend = 1'b1; do_start = !is_blank;
            end
          end
          M_INT: begin
            if (is_dig) begin
              iacc_nxt = (iprod > 35'h7FFF_FFFF) ? 31'h7FFF_FFFF : iprod[30:0];
              text_nxt = app_text(text_r, cnt_r, char_code); cnt_nxt = app_cnt(cnt_r);
            end else if (char_code == 8'h2E) begin
              text_nxt = app_text(text_r, cnt_r, char_code); cnt_nxt = app_cnt(cnt_r);
              pk_nxt = K_DEC; mode_nxt = M_DEC;
            end else begin
              do_pend = 1'b1; do_start = !is_blank;
            end
          end
          M_DEC: begin
            if (is_dig) begin
              text_nxt = app_text(text_r, cnt_r, char_code); cnt_nxt = app_cnt(cnt_r);
              if (fcnt_r < 4'(MAX_FRAC)) begin
                facc_nxt = 30'((facc_r << 3) + (facc_r << 1) + 30'(dval));
                fcnt_nxt = fcnt_r + 4'd1;
              end
            end else begin
              do_pend = 1'b1; do_start = !is_blank;
            end
          end
          M_EQ, M_BANG, M_REL: begin
            if (char_code == 8'h3D) begin
              ptext = app_text(text_r, cnt_r, char_code); pcnt = app_cnt(cnt_r);
              do_pend = 1'b1; pend_kind = K_COMPARE;
            end else if (char_code == 8'h20 && mode_r != M_BANG) begin
              do_pend = 1'b1;
              pend_kind = (mode_r == M_EQ) ? K_ASSIGN : K_COMPARE;
            end else begin
              tok0 = mk(K_ERROR, line_r, col_r, '0, '0, '0, {56'd0, char_code}, 5'd1);
              err_nxt = 1'b1; n = 2'd1; mode_nxt = M_IDLE;
            end
          end
          default: begin
            mode_nxt = M_IDLE;
            do_start = !is_blank;
          end
        endcase
      end
      if (char_code == 8'h0A) begin
        if (line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
        col_nxt = 16'd1;
      end else if (col_r != 16'hFFFF) begin
        col_nxt = col_r + 16'd1;
      end
    end

    // pending token always lands in the first slot
    pend_tok = mk(pend_kind, tline_r, tcol_r,
                  (pend_kind == K_INT || pend_kind == K_DEC) ? iacc_r : 31'd0,
                  (pend_kind == K_DEC) ? facc_r : 30'd0,
                  (pend_kind == K_DEC) ? fcnt_r : 4'd0, ptext, pcnt);
    if (do_pend) begin
      tok0 = pend_tok; n = 2'd1; mode_nxt = M_IDLE;
    end

    // token start
    case (char_code)
      8'h2B: single = K_PLUS;
      8'h2D: single = K_MINUS;
      8'h2A: single = K_STAR;
      8'h2F: single = K_SLASH;
      8'h28: single = K_LPAR;
      8'h29: single = K_RPAR;
      8'h3B: single = K_SEMI;
      default: single = K_ERROR;
    endcase
    start_tok = mk(single, line_r, col_r, '0, '0, '0, {56'd0, char_code}, 5'd1);
    if (do_start) begin
      tline_nxt = line_r; tcol_nxt = col_r;
      text_nxt = {56'd0, char_code}; cnt_nxt = 5'd1;
      iacc_nxt = '0; facc_nxt = '0; fcnt_nxt = '0;
      mode_nxt = M_IDLE;
      if (is_dig) begin
        iacc_nxt = {27'd0, dval}; pk_nxt = K_INT; mode_nxt = M_INT;
      end else if (is_let) begin
        pk_nxt = K_IDENT; mode_nxt = M_IDENT;
      end else if (char_code == 8'h2E) begin
        pk_nxt = K_DEC; mode_nxt = M_DEC;
      end else if (char_code == 8'h3D) begin
        mode_nxt = M_EQ;
      end else if (char_code == 8'h21) begin
        mode_nxt = M_BANG;
      end else if (char_code == 8'h3C || char_code == 8'h3E) begin
        mode_nxt = M_REL;
      end else begin
        st_emit = 1'b1;
        if (single == K_ERROR) err_nxt = 1'b1;
      end
      if (st_emit) begin
        if (n == 2'd0) tok0 = start_tok;
        else tok1 = start_tok;
        n = n + 2'd1;
      end
    end

    // end token follows any flushed pending token
    if (end_of_input && !(err_r || mode_r == M_EQ || mode_r == M_BANG || mode_r == M_REL)) begin
      if (n == 2'd0) tok0 = mk(K_END, line_r, col_r, '0, '0, '0, '0, '0);
      else tok1 = mk(K_END, line_r, col_r, '0, '0, '0, '0, '0);
      n = n + 2'd1;
    end

    if (n == 2'd1) tok0.last = 1'b1;
    if (n == 2'd2) tok1.last = 1'b1;
    push_cnt = acc_en ? n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; pk_r <= '0; text_r <= '0; cnt_r <= '0;
      iacc_r <= '0; facc_r <= '0; fcnt_r <= '0;
      line_r <= 16'd1; col_r <= 16'd1; tline_r <= 16'd1; tcol_r <= 16'd1;
      err_r <= 1'b0;
    end else if (acc_en) begin
      mode_r <= mode_nxt; pk_r <= pk_nxt; text_r <= text_nxt; cnt_r <= cnt_nxt;
      iacc_r <= iacc_nxt; facc_r <= facc_nxt; fcnt_r <= fcnt_nxt;
      line_r <= line_nxt; col_r <= col_nxt; tline_r <= tline_nxt; tcol_r <= tcol_nxt;
      err_r <= err_nxt;
    end
  end

  // once latched, the error flag never drops without reset
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(err_r) && $past(rst_n) |-> err_r) else $error("error latch cleared");
  // fraction count never exceeds its limit
  a_frac_lim: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= 4'(MAX_FRAC)) else $error("fraction count overflow");

endmodule

// ----- rtl/etok_queue.sv -----
// Token queue between scanner and output stage: up to two writes, one read per cycle.
// Depends on etok_pkg.
module etok_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     push_cnt,
  input  etok_pkg::tok_t d0,
  input  etok_pkg::tok_t d1,
  input  logic           pop,
  output etok_pkg::tok_t head,
  output logic           not_empty,
  output logic           room2
);
  import etok_pkg::*;

  tok_t          mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign head      = mem_r[rp_r];
  assign not_empty = (cnt_r != '0);
  assign room2     = (cnt_r <= (QAW+1)'(QDEPTH - 2));
  assign cnt_nxt   = cnt_r + (QAW+1)'(push_cnt) - (QAW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wp_r] <= d0;
    if (push_cnt == 2'd2) mem_r[wp_r + QAW'(1)] <= d1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + QAW'(push_cnt);
      rp_r  <= rp_r + QAW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt != 2'd0 |-> room2) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("queue underflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH)) else $error("queue count out of range");

endmodule

// ----- rtl/etok_back.sv -----
// Output stage: keyword lookup on identifiers and the result register.
// Depends on etok_pkg.
module etok_back (
  input  logic           clk,
  input  logic           rst_n,
  input  etok_pkg::tok_t head,
  input  logic           not_empty,
  output logic           pop,
  input  logic           out_ready,
  output logic           out_valid,
  output etok_pkg::tok_t res
);
  import etok_pkg::*;

  logic  valid_r;
  tok_t  res_r;
  tok_t  looked;

  always_comb begin
    looked = head;
    if (head.kind == K_IDENT) begin
      for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
        if (head.tlen == KW_TABLE[i].len && head.text == KW_TABLE[i].word)
          looked.kind = KW_TABLE[i].kind;
      end
    end
  end

  assign pop       = not_empty && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (!valid_r || out_ready) valid_r <= not_empty;
  end

  always_ff @(posedge clk) begin
    if (pop) res_r <= looked;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |=> valid_r && $stable(res_r)) else $error("result dropped");

endmodule

// ----- rtl/expression_tokenizer.sv -----
// Top level of the expression tokenizer: scanner, token queue, output stage.
// Depends on etok_pkg, etok_front, etok_queue, etok_back.
//
// Usage:
//  - Input channel (in_valid/in_ready): one character per transfer, or an
//    end mark (in_end_of_input = 1, character ignored).
//  - Result channel (out_valid/out_ready): one token per transfer; a single
//    input may yield zero, one or two tokens, out_last_result flags the last.
//  - Throughput: one character per cycle while in_ready is high. The
//    scanner pushes up to two tokens into a four-entry queue; the output
//    stage drains one token per cycle while out_ready is high, so a run of
//    inputs yielding two tokens each is bound by the queue's single read port.
//  - Path: a token is written into the queue when the character ending it
//    is taken, then moves into the result register, which drives the
//    output, when the output stage pops it; a waiting result holds it back.
//  - in_ready is high while the queue has room for two tokens; the scanner
//    keeps working while a finished result waits in the result register.
//  - Receiver stall: the result holds, the queue fills, then in_ready drops.
//  - Reset: scanner idle, line and column 1, error latch clear, queue empty.
//    A bad character latches an error that only reset clears.
module expression_tokenizer #(
  parameter int TEXT_BYTES = etok_pkg::TEXT_BYTES_DEF,
  parameter int MAX_FRAC   = etok_pkg::MAX_FRAC_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_kind,
  output logic [15:0] out_start_line,
  output logic [15:0] out_start_column,
  output logic [30:0] out_int_value,
  output logic [29:0] out_frac_value,
  output logic [3:0]  out_frac_digits,
  output logic [63:0] out_token_text,
  output logic [4:0]  out_text_length,
  output logic        out_last_result
);
  import etok_pkg::*;

  logic       acc_en, pop, not_empty, room2;
  logic [1:0] push_cnt;
  tok_t       tok0, tok1, head, res;

  // transfer into the scanner only when the queue can take both tokens
  assign in_ready = room2;
  assign acc_en   = in_valid && room2;

  etok_front #(.TEXT_BYTES(TEXT_BYTES), .MAX_FRAC(MAX_FRAC)) u_front (
    .clk, .rst_n, .acc_en,
    .char_code(in_char_code), .end_of_input(in_end_of_input),
    .push_cnt, .tok0, .tok1
  );

  etok_queue u_queue (
    .clk, .rst_n, .push_cnt, .d0(tok0), .d1(tok1), .pop,
    .head, .not_empty, .room2
  );

  etok_back u_back (
    .clk, .rst_n, .head, .not_empty, .pop, .out_ready, .out_valid, .res
  );

  assign out_token_kind   = res.kind;
  assign out_start_line   = res.line;
  assign out_start_column = res.col;
  assign out_int_value    = res.ival;
  assign out_frac_value   = res.fval;
  assign out_frac_digits  = res.fdig;
  assign out_token_text   = res.text;
  assign out_text_length  = res.tlen;
  assign out_last_result  = res.last;

endmodule
